>>> src/hash_set_insert_search_top_defines.svh
// Assertion macros shared by the hash set RTL.
`ifndef HASH_SET_INSERT_SEARCH_TOP_DEFINES_SVH
`define HASH_SET_INSERT_SEARCH_TOP_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define HSIS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define HSIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> src/hsis_pkg.sv
// Types and constants shared by the hash set front end, queue and back end.
package hsis_pkg;

	localparam int KEY_W = 32;
	localparam int STEP_BITS = 4;
	localparam int STEPS = KEY_W / STEP_BITS;
	localparam int CNT_W = $clog2(STEPS);
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_SEARCH = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_PRESENT   = 3'd2,
		ST_ABSENT    = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_REDUCE,
		FR_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

>>> src/hsis_front.sv
// Front end: accepts items and reduces each key to its bucket index.
module hsis_front #(
	parameter int BUCKETS = 1024
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic                                        func,
	input  logic signed [hsis_pkg::KEY_W-1:0]           key,
	input  logic                                        clearing,
	input  hsis_pkg::fifo_stat_t                        q_stat,
	output logic                                        busy,
	output logic                                        push,
	output logic [hsis_pkg::KEY_W+$clog2(BUCKETS):0]    ent
);

	localparam int BW = $clog2(BUCKETS);
	localparam int RW = BW + 1;
	localparam int KW = hsis_pkg::KEY_W;
	localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

	logic [KW-1:0] key_mag;

	assign key_mag = key[KW-1] ? (~key + KW'(1)) : key;

	if (POW2) begin : g_mask
		logic          vld_s1;
		logic          func_s1;
		logic [KW-1:0] key_s1;
		logic [BW-1:0] bkt_s1;
		logic          take;

		assign busy = clearing || (vld_s1 && q_stat.full);
		assign take = start && !busy;
		assign push = vld_s1 && !q_stat.full;
		assign ent  = {func_s1, key_s1, bkt_s1};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1 <= 1'b0;
			end else if (take) begin
				vld_s1 <= 1'b1;
			end else if (push) begin
				vld_s1 <= 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			if (take) begin
				func_s1 <= func;
				key_s1  <= key;
				bkt_s1  <= key_mag[BW-1:0];
			end
		end
	end else begin : g_reduce
		hsis_pkg::front_state_t   state_q, state_d;
		logic                     func_q;
		logic [KW-1:0]            key_q;
		logic [KW-1:0]            mag_q;
		logic [BW-1:0]            rem_q;
		logic [hsis_pkg::CNT_W-1:0] cnt_q;
		logic [RW-1:0]            rem_next;
		logic                     take;
		logic                     step;

		always_comb begin
			rem_next = {1'b0, rem_q};
			for (int i = 0; i < hsis_pkg::STEP_BITS; i++) begin
				rem_next = {rem_next[BW-1:0], mag_q[KW-1-i]};
				if (rem_next >= RW'(BUCKETS)) begin
					rem_next = rem_next - RW'(BUCKETS);
				end
			end
		end

		always_comb begin
			state_d = state_q;
			take = 1'b0;
			step = 1'b0;
			push = 1'b0;
			busy = 1'b1;
			case (state_q)
				hsis_pkg::FR_IDLE: begin
					busy = clearing;
					if (start && !clearing) begin
						take = 1'b1;
						state_d = hsis_pkg::FR_REDUCE;
					end
				end
				hsis_pkg::FR_REDUCE: begin
					step = 1'b1;
					if (cnt_q == hsis_pkg::CNT_W'(hsis_pkg::STEPS - 1)) begin
						state_d = hsis_pkg::FR_PUSH;
					end
				end
				hsis_pkg::FR_PUSH: begin
					if (!q_stat.full) begin
						push = 1'b1;
						state_d = hsis_pkg::FR_IDLE;
					end
				end
				default: begin
					state_d = hsis_pkg::FR_IDLE;
				end
			endcase
		end

		assign ent = {func_q, key_q, rem_q};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				state_q <= hsis_pkg::FR_IDLE;
			end else begin
				state_q <= state_d;
			end
		end

		always_ff @(posedge clk) begin
			if (take) begin
				func_q <= func;
				key_q  <= key;
				mag_q  <= key_mag;
				rem_q  <= '0;
				cnt_q  <= '0;
			end else if (step) begin
				mag_q  <= mag_q << hsis_pkg::STEP_BITS;
				rem_q  <= rem_next[BW-1:0];
				cnt_q  <= cnt_q + hsis_pkg::CNT_W'(1);
			end
		end
	end

endmodule

>>> src/hsis_queue.sv
// Two-entry queue that decouples the front end from the back end.
module hsis_queue #(
	parameter int W = 43
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [W-1:0]         wr_data,
	input  logic                 pop,
	output logic [W-1:0]         rd_data,
	output hsis_pkg::fifo_stat_t q_stat
);

	logic [W-1:0]                mem_q [hsis_pkg::QDEPTH];
	logic [hsis_pkg::QPTR_W-1:0] wr_q;
	logic [hsis_pkg::QPTR_W-1:0] rd_q;
	logic [hsis_pkg::QCNT_W-1:0] cnt_q;

	assign rd_data      = mem_q[rd_q];
	assign q_stat.full  = cnt_q == hsis_pkg::QCNT_W'(hsis_pkg::QDEPTH);
	assign q_stat.empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + hsis_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + hsis_pkg::QPTR_W'(1);
			end
			cnt_q <= cnt_q + hsis_pkg::QCNT_W'(push) - hsis_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

endmodule

>>> src/hsis_back.sv
// Back end: reads a bucket row, compares all ways, writes back and reports.
module hsis_back #(
	parameter int BUCKETS = 1024,
	parameter int WAYS = 4
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  hsis_pkg::fifo_stat_t                     q_stat,
	input  logic [hsis_pkg::KEY_W+$clog2(BUCKETS):0] q_ent,
	output logic                                     pop,
	output logic                                     clearing,
	output logic                                     done,
	output logic [2:0]                               status
);

	localparam int BW = $clog2(BUCKETS);
	localparam int KW = hsis_pkg::KEY_W;
	localparam int ROW_W = WAYS * KW;

	logic [ROW_W-1:0]        key_mem [BUCKETS];
	logic [WAYS-1:0]         vld_mem [BUCKETS];

	hsis_pkg::back_state_t   state_q, state_d;
	logic [BW-1:0]           clr_q;
	hsis_pkg::func_t         func_q;
	logic [KW-1:0]           key_q;
	logic [BW-1:0]           bkt_q;
	logic [ROW_W-1:0]        krow_q;
	logic [WAYS-1:0]         vrow_q;
	logic                    done_q;
	hsis_pkg::status_t       status_q;

	hsis_pkg::func_t         q_func;
	logic [KW-1:0]           q_key;
	logic [BW-1:0]           q_bkt;
	logic [WAYS-1:0]         hit;
	logic [WAYS-1:0]         free;
	logic [WAYS-1:0]         free_oh;
	logic                    found;
	logic                    have_free;
	logic                    ins_we;
	logic [ROW_W-1:0]        krow_new;
	hsis_pkg::status_t       status_d;
	logic                    exec;
	logic                    kwe;
	logic                    vwe;
	logic [BW-1:0]           vwaddr;
	logic [WAYS-1:0]         vwdata;

	assign q_func = hsis_pkg::func_t'(q_ent[KW+BW]);
	assign q_key  = q_ent[BW +: KW];
	assign q_bkt  = q_ent[BW-1:0];

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			hit[w] = vrow_q[w] && (krow_q[w*KW +: KW] == key_q);
		end
	end

	assign free      = ~vrow_q;
	assign free_oh   = free & (~free + WAYS'(1));
	assign found     = |hit;
	assign have_free = |free;
	assign ins_we    = (func_q == hsis_pkg::FUNC_INSERT) && !found && have_free;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			krow_new[w*KW +: KW] = free_oh[w] ? key_q : krow_q[w*KW +: KW];
		end
	end

	always_comb begin
		if (func_q == hsis_pkg::FUNC_INSERT) begin
			if (found) begin
				status_d = hsis_pkg::ST_DUPLICATE;
			end else if (have_free) begin
				status_d = hsis_pkg::ST_INSERTED;
			end else begin
				status_d = hsis_pkg::ST_FULL;
			end
		end else begin
			status_d = found ? hsis_pkg::ST_PRESENT : hsis_pkg::ST_ABSENT;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		exec     = 1'b0;
		clearing = 1'b0;
		case (state_q)
			hsis_pkg::BK_CLEAR: begin
				clearing = 1'b1;
				if (clr_q == BW'(BUCKETS - 1)) begin
					state_d = hsis_pkg::BK_IDLE;
				end
			end
			hsis_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					pop = 1'b1;
					state_d = hsis_pkg::BK_EXEC;
				end
			end
			hsis_pkg::BK_EXEC: begin
				exec = 1'b1;
				state_d = hsis_pkg::BK_IDLE;
			end
			default: begin
				state_d = hsis_pkg::BK_CLEAR;
			end
		endcase
		kwe    = exec && ins_we;
		vwe    = clearing || kwe;
		vwaddr = clearing ? clr_q : bkt_q;
		vwdata = clearing ? '0 : (vrow_q | free_oh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsis_pkg::BK_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= exec;
			if (clearing) begin
				clr_q <= clr_q + BW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			func_q <= q_func;
			key_q  <= q_key;
			bkt_q  <= q_bkt;
		end
		if (exec) begin
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		if (kwe) begin
			key_mem[bkt_q] <= krow_new;
		end
		if (pop) begin
			krow_q <= key_mem[q_bkt];
		end
	end

	always_ff @(posedge clk) begin
		if (vwe) begin
			vld_mem[vwaddr] <= vwdata;
		end
		if (pop) begin
			vrow_q <= vld_mem[q_bkt];
		end
	end

	assign done   = done_q;
	assign status = status_q;

endmodule

>>> src/hash_set_insert_search_top.sv
// Top level of the hash set with bucketed storage for insert and search of keys.
//
// An item (func, key) is accepted at a rising edge where start is high and busy
// is low. Each item gives exactly one result: status is valid while done is high,
// for one cycle, and the receiver takes it at the edge that ends that cycle.
// The receiver cannot stall; results are never held back for it.
// The front end registers the item and works out the key's bucket; a two-entry
// queue then feeds the back end, which reads the bucket row and then, in the
// next cycle, compares all ways and writes the row back if an insert stores the
// key. The back end takes no new item from the queue until it has finished the
// last one. When BUCKETS is a power of two, the bucket is the low bits of the
// key's magnitude, registered with the item. Otherwise the bucket is reduced
// four key bits a cycle, and the front end takes each item through an accepting
// state, the reduction steps and a push state that waits while the queue is
// full; no new item is taken before the last is pushed, so it sets the rate.
// After reset a pass clears the valid bits one bucket a cycle, with busy high.
`include "hash_set_insert_search_top_defines.svh"

module hash_set_insert_search_top #(
	parameter int BUCKETS = 1024,
	parameter int WAYS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              func,
	input  logic signed [hsis_pkg::KEY_W-1:0] key,
	output logic                              done,
	output logic [2:0]                        status
);

	localparam int ENT_W = hsis_pkg::KEY_W + $clog2(BUCKETS) + 1;

	logic                 push;
	logic                 pop;
	logic                 clearing;
	logic [ENT_W-1:0]     ent;
	logic [ENT_W-1:0]     q_ent;
	hsis_pkg::fifo_stat_t q_stat;

	hsis_front #(
		.BUCKETS(BUCKETS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.func(func),
		.key(key),
		.clearing(clearing),
		.q_stat(q_stat),
		.busy(busy),
		.push(push),
		.ent(ent)
	);

	hsis_queue #(
		.W(ENT_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(ent),
		.pop(pop),
		.rd_data(q_ent),
		.q_stat(q_stat)
	);

	hsis_back #(
		.BUCKETS(BUCKETS),
		.WAYS(WAYS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.q_ent(q_ent),
		.pop(pop),
		.clearing(clearing),
		.done(done),
		.status(status)
	);

	`HSIS_ASSERT_NEXT(a_done_spaced, done, !done, "result strobes in consecutive cycles")
	`HSIS_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "queue popped while empty")
	`HSIS_ASSERT_NOW(a_push_room, push, !q_stat.full, "queue pushed while full")
	`HSIS_ASSERT_NOW(a_clear_busy, clearing, busy, "item accepted during the clearing pass")

endmodule

>>> tb/sv/tb_hash_set_insert_search_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the hash set insert and search block with bucketed storage.
module tb_hash_set_insert_search_top;
	import hsis_pkg::*;

	localparam int BUCKETS = 1024;
	localparam int WAYS = 4;
	localparam int SLOTS = BUCKETS * WAYS;
	localparam int MAX_MULT = (32'h7FFF_FFFF - (BUCKETS - 1)) / BUCKETS;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    func;
	logic signed [KEY_W-1:0] key;
	logic                    done;
	logic [2:0]              status;

	logic [KEY_W-1:0] slot_key [SLOTS];
	bit               slot_used [SLOTS];
	logic [KEY_W-1:0] stored_keys [$];
	status_t          pending_status [$];
	int               err_count;
	bit               idle_on;

	hash_set_insert_search_top #(
		.BUCKETS(BUCKETS),
		.WAYS(WAYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.key(key),
		.done(done),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		err_count++;
	endtask

	// Works out the status of one item and updates the table copy.
	function automatic status_t lookup_status(input func_t op, input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] mag;
		int               base;
		bit               found;
		bit               have_free;
		int               free_idx;
		mag = k[KEY_W-1] ? (~k + 1'b1) : k;
		base = int'(mag % 32'(BUCKETS)) * WAYS;
		found = 1'b0;
		have_free = 1'b0;
		free_idx = 0;
		for (int w = 0; w < WAYS; w++) begin
			if (slot_used[base + w]) begin
				if (slot_key[base + w] == k)
					found = 1'b1;
			end else if (!have_free) begin
				have_free = 1'b1;
				free_idx = base + w;
			end
		end
		if (op == FUNC_SEARCH)
			return found ? ST_PRESENT : ST_ABSENT;
		if (found)
			return ST_DUPLICATE;
		if (!have_free)
			return ST_FULL;
		slot_key[free_idx] = k;
		slot_used[free_idx] = 1'b1;
		stored_keys.push_back(k);
		return ST_INSERTED;
	endfunction

	task automatic send_item(input func_t op, input logic [KEY_W-1:0] k);
		start <= 1'b1;
		func <= op;
		key <= k;
		do @(posedge clk); while (busy);
		pending_status.push_back(lookup_status(op, k));
		if (idle_on && $urandom_range(99) < 35) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : check_results
		status_t want;
		if (arst_n && done) begin
			if (pending_status.size() == 0) begin
				report_mismatch($sformatf("result with status %0d but no item pending",
					status));
			end else begin
				want = pending_status.pop_front();
				if (status !== want)
					report_mismatch($sformatf("status %0d, expected %0d (%s)",
						status, want, want.name()));
			end
		end
	end

	task automatic test_basic_insert_search();
		send_item(FUNC_SEARCH, 32'd0);
		send_item(FUNC_INSERT, 32'd0);
		send_item(FUNC_INSERT, 32'd0);
		send_item(FUNC_SEARCH, 32'd0);
		send_item(FUNC_SEARCH, 32'd1);
	endtask

	// The most negative key shares bucket zero; a key and its negation are distinct.
	task automatic test_extreme_keys();
		send_item(FUNC_INSERT, 32'h8000_0000);
		send_item(FUNC_SEARCH, 32'h8000_0000);
		send_item(FUNC_INSERT, 32'h7FFF_FFFF);
		send_item(FUNC_SEARCH, 32'hFFFF_FFFF);
		send_item(FUNC_INSERT, 32'hFFFF_FFFF);
		send_item(FUNC_SEARCH, 32'd1);
	endtask

	// Fills one bucket, then checks full, duplicates in the last way and in a full row.
	task automatic test_full_bucket();
		send_item(FUNC_INSERT, 32'd5);
		send_item(FUNC_INSERT, -32'sd5);
		send_item(FUNC_INSERT, 32'd5 + BUCKETS);
		send_item(FUNC_INSERT, -(32'sd5 + BUCKETS));
		send_item(FUNC_INSERT, 32'd5 + 2 * BUCKETS);
		send_item(FUNC_INSERT, -(32'sd5 + BUCKETS));
		send_item(FUNC_INSERT, 32'd5);
		send_item(FUNC_SEARCH, 32'd5 + 2 * BUCKETS);
		send_item(FUNC_SEARCH, -(32'sd5 + BUCKETS));
	endtask

	// Most keys land in a few busy buckets so that rows fill and keys repeat.
	task automatic test_random_mix(input int count);
		int               sel;
		int               row;
		logic [KEY_W-1:0] mag;
		logic [KEY_W-1:0] k;
		func_t            op;
		for (int i = 0; i < count; i++) begin
			idle_on = !(i >= count * 2 / 5 && i < count * 3 / 5);
			sel = $urandom_range(99);
			if (sel < 45 && stored_keys.size() > 0) begin
				k = stored_keys[$urandom_range(stored_keys.size() - 1)];
				if (sel >= 35)
					k = ~k + 1'b1;
			end else if (sel < 80) begin
				row = ($urandom_range(11) * 89) % BUCKETS;
				mag = row + BUCKETS * $urandom_range(MAX_MULT);
				k = $urandom_range(1) ? (~mag + 1'b1) : mag;
			end else begin
				k = $urandom();
			end
			op = func_t'($urandom_range(1));
			send_item(op, k);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FUNC_INSERT;
		key <= '0;
		err_count = 0;
		idle_on = 1'b1;
		for (int i = 0; i < SLOTS; i++) begin
			slot_key[i] = '0;
			slot_used[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_insert_search();
		test_extreme_keys();
		test_full_bucket();
		test_random_mix(400);
		start <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
